[design/fpln_pkg.sv]
// shared types, constants and lookup tables of the fixed-point natural log unit
`timescale 1ns / 1ps
package fpln_pkg;

	localparam logic [31:0] LN2_U27    = 32'd93032640;
	localparam logic [31:0] LN2_X16    = 32'd1488522240;
	localparam logic [30:0] CUBIC_COEF = 31'd1431667232;
	localparam logic [19:0] OFFSET_12  = 20'd393216;

	// ln(1 + k/64) + 12 in u5.27
	localparam logic [31:0] LOG_CK_TAB [0:64] = '{
		32'd1610612736, 32'd1612693673, 32'd1614742838, 32'd1616761188,
		32'd1618749635, 32'd1620709053, 32'd1622640276, 32'd1624544106,
		32'd1626421307, 32'd1628272616, 32'd1630098736, 32'd1631900343,
		32'd1633678087, 32'd1635432592, 32'd1637164458, 32'd1638874261,
		32'd1640562556, 32'd1642229879, 32'd1643876743, 32'd1645503644,
		32'd1647111061, 32'd1648699455, 32'd1650269271, 32'd1651820939,
		32'd1653354872, 32'd1654871473, 32'd1656371128, 32'd1657854212,
		32'd1659321087, 32'd1660772103, 32'd1662207601, 32'd1663627908,
		32'd1665033342, 32'd1666424211, 32'd1667800815, 32'd1669163444,
		32'd1670512377, 32'd1671847888, 32'd1673170241, 32'd1674479692,
		32'd1675776492, 32'd1677060882, 32'd1678333097, 32'd1679593367,
		32'd1680841913, 32'd1682078952, 32'd1683304693, 32'd1684519341,
		32'd1685723096, 32'd1686916150, 32'd1688098693, 32'd1689270907,
		32'd1690432973, 32'd1691585063, 32'd1692727349, 32'd1693859995,
		32'd1694983162, 32'd1696097009, 32'd1697201687, 32'd1698297348,
		32'd1699384138, 32'd1700462197, 32'd1701531667, 32'd1702592682,
		32'd1703645376
	};

	// reciprocal correction 1/c_k - 1, signed with 16 fraction bits (entry / 2^16)
	localparam logic signed [15:0] RECIP_TAB [0:64] = '{
		16'sd0,      -16'sd1008,  -16'sd1986,  -16'sd2934,
		-16'sd3855,  -16'sd4749,  -16'sd5617,  -16'sd6461,
		-16'sd7282,  -16'sd8080,  -16'sd8856,  -16'sd9612,
		-16'sd10348, -16'sd11065, -16'sd11763, -16'sd12444,
		-16'sd13107, -16'sd13754, -16'sd14386, -16'sd15002,
		-16'sd15604, -16'sd16191, -16'sd16765, -16'sd17326,
		-16'sd17873, -16'sd18409, -16'sd18933, -16'sd19445,
		-16'sd19946, -16'sd20436, -16'sd20916, -16'sd21385,
		-16'sd21845, -16'sd22296, -16'sd22737, -16'sd23169,
		-16'sd23593, -16'sd24008, -16'sd24415, -16'sd24815,
		-16'sd25206, -16'sd25590, -16'sd25967, -16'sd26337,
		-16'sd26700, -16'sd27056, -16'sd27406, -16'sd27749,
		-16'sd28087, -16'sd28418, -16'sd28744, -16'sd29064,
		-16'sd29378, -16'sd29687, -16'sd29991, -16'sd30290,
		-16'sd30583, -16'sd30872, -16'sd31156, -16'sd31436,
		-16'sd31711, -16'sd31982, -16'sd32248, -16'sd32510,
		-16'sd32768
	};

	typedef struct packed {
		logic        valid;
		logic        err;
		logic [31:0] x;
		logic [4:0]  shift;
	} s1_t;

	typedef struct packed {
		logic        valid;
		logic        err;
		logic [31:0] z;
		logic [6:0]  k;
		logic [31:0] lnsh;
	} s2_t;

	typedef struct packed {
		logic        valid;
		logic        err;
		logic [26:0] rem;
		logic [15:0] recip;
		logic [31:0] logck;
		logic [31:0] lnsh;
	} s3_t;

	typedef struct packed {
		logic        valid;
		logic        err;
		logic [27:0] r1;
		logic [31:0] logck;
		logic [31:0] lnsh;
	} s4_t;

	typedef struct packed {
		logic        valid;
		logic        err;
		logic [27:0] r1;
		logic [7:0]  tq;
		logic [31:0] logck;
		logic [31:0] lnsh;
	} s5_t;

	typedef struct packed {
		logic        valid;
		logic        err;
		logic [27:0] r1;
		logic [22:0] c;
		logic [31:0] logck;
		logic [31:0] lnsh;
	} s6_t;

	typedef struct packed {
		logic        valid;
		logic        err;
		logic [28:0] r2;
		logic [31:0] logck;
		logic [31:0] lnsh;
	} s7_t;

endpackage

[design/fpln_in_if.sv]
// argument channel of the natural log unit
`timescale 1ns / 1ps
interface fpln_in_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] x_value;

	modport source (output valid, output x_value, input ready);
	modport sink (input valid, input x_value, output ready);
endinterface

[design/fpln_out_if.sv]
// result channel of the natural log unit
`timescale 1ns / 1ps
interface fpln_out_if;
	logic               valid;
	logic               ready;
	logic signed [19:0] log_result;
	logic               domain_error;

	modport source (output valid, output log_result, output domain_error, input ready);
	modport sink (input valid, input log_result, input domain_error, output ready);
endinterface

[design/fpln_norm.sv]
// normalization stages: leading-zero count, mantissa shift, breakpoint index
`timescale 1ns / 1ps
module fpln_norm import fpln_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        in_valid,
	input  logic [31:0] x,
	output s2_t         st_s2
);

	function automatic logic [4:0] lead_zeros(input logic [31:0] v);
		logic [4:0] n;
		n = 5'd0;
		for (int i = 0; i < 32; i++) begin
			if (v[i]) begin
				n = 5'(31 - i);
			end
		end
		return n;
	endfunction

	s1_t         st_s1;
	s1_t         nxt1;
	s2_t         nxt2;
	logic [31:0] z;

	always_comb begin
		nxt1.valid = in_valid;
		nxt1.err   = (x == 32'd0) | x[31];
		nxt1.x     = x;
		nxt1.shift = lead_zeros(x);
	end

	// drop the leading one, round the top fraction bits to a breakpoint
	assign z = st_s1.x << (6'(st_s1.shift) + 6'd1);

	always_comb begin
		nxt2.valid = st_s1.valid;
		nxt2.err   = st_s1.err;
		nxt2.z     = z;
		nxt2.k     = {1'b0, z[31:26]} + {6'b0, z[25]};
		nxt2.lnsh  = LN2_X16 - (32'(st_s1.shift) * LN2_U27);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_s1.valid <= 1'b0;
			st_s2.valid <= 1'b0;
		end else if (en) begin
			st_s1 <= nxt1;
			st_s2 <= nxt2;
		end
	end

endmodule

[design/fpln_reduce.sv]
// table lookup and first-order reduction of the remainder
`timescale 1ns / 1ps
module fpln_reduce import fpln_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  s2_t  st_s2,
	output s4_t  st_s4
);

	s3_t                st_s3;
	s3_t                nxt3;
	s4_t                nxt4;
	logic [32:0]        rem_full;
	logic signed [42:0] prod;

	// remainder from the chosen breakpoint, always within +-2^25
	assign rem_full = {1'b0, st_s2.z} - {st_s2.k, 26'b0};

	always_comb begin
		nxt3.valid = st_s2.valid;
		nxt3.err   = st_s2.err;
		nxt3.rem   = rem_full[26:0];
		nxt3.recip = RECIP_TAB[st_s2.k];
		nxt3.logck = LOG_CK_TAB[st_s2.k];
		nxt3.lnsh  = st_s2.lnsh;
	end

	assign prod = $signed(st_s3.rem) * $signed(st_s3.recip);

	always_comb begin
		nxt4.valid = st_s3.valid;
		nxt4.err   = st_s3.err;
		nxt4.r1    = {st_s3.rem[26], st_s3.rem} + {prod[42], prod[42:16]};
		nxt4.logck = st_s3.logck;
		nxt4.lnsh  = st_s3.lnsh;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_s3.valid <= 1'b0;
			st_s4.valid <= 1'b0;
		end else if (en) begin
			st_s3 <= nxt3;
			st_s4 <= nxt4;
		end
	end

endmodule

[design/fpln_cubic.sv]
// cubic correction term, one multiply per stage
`timescale 1ns / 1ps
module fpln_cubic import fpln_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  s4_t  st_s4,
	output s7_t  st_s7
);

	s5_t                st_s5;
	s6_t                st_s6;
	s5_t                nxt5;
	s6_t                nxt6;
	s7_t                nxt7;
	logic signed [23:0] sq;
	logic [38:0]        cp;
	logic signed [35:0] ct;
	logic [19:0]        t3;

	// square of the top 12 bits
	assign sq = $signed(st_s4.r1[27:16]) * $signed(st_s4.r1[27:16]);

	always_comb begin
		nxt5.valid = st_s4.valid;
		nxt5.err   = st_s4.err;
		nxt5.r1    = st_s4.r1;
		nxt5.tq    = sq[23:16];
		nxt5.logck = st_s4.logck;
		nxt5.lnsh  = st_s4.lnsh;
	end

	assign cp = CUBIC_COEF * st_s5.tq;

	always_comb begin
		nxt6.valid = st_s5.valid;
		nxt6.err   = st_s5.err;
		nxt6.r1    = st_s5.r1;
		nxt6.c     = cp[38:16];
		nxt6.logck = st_s5.logck;
		nxt6.lnsh  = st_s5.lnsh;
	end

	assign ct = $signed({1'b0, st_s6.c}) * $signed(st_s6.r1[27:16]);
	assign t3 = ct[35:16];

	always_comb begin
		nxt7.valid = st_s6.valid;
		nxt7.err   = st_s6.err;
		nxt7.r2    = {st_s6.r1[27], st_s6.r1} + {{9{t3[19]}}, t3};
		nxt7.logck = st_s6.logck;
		nxt7.lnsh  = st_s6.lnsh;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_s5.valid <= 1'b0;
			st_s6.valid <= 1'b0;
			st_s7.valid <= 1'b0;
		end else if (en) begin
			st_s5 <= nxt5;
			st_s6 <= nxt6;
			st_s7 <= nxt7;
		end
	end

endmodule

[design/fixed_point_natural_log_unit.sv]
// top level of the pipelined s16.15 natural log unit
`timescale 1ns / 1ps
//
// channel   dir   payload                                   word
// in_ch     in    x_value s32 (s16.15)                      one argument
// out_ch    out   log_result s20 (s4.15), domain_error u1   one result
//
// one word enters per cycle unless out_ch stalls; each argument passes through the stages
// (two normalize stages, two reduction stages, three cubic stages, one output)
// the output register can hold a finished word while the pipe keeps its content
// a stall at out_ch freezes all stages together, so in_ch.ready drops with it
// arst_n clears only the valid bits, payload registers are left as they are
module fixed_point_natural_log_unit import fpln_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	fpln_in_if.sink    in_ch,
	fpln_out_if.source out_ch
);

	logic        en;
	s2_t         st_s2;
	s4_t         st_s4;
	s7_t         st_s7;
	logic [31:0] sum;
	logic [20:0] rnd;
	logic [20:0] res;
	logic        out_valid_q;
	logic [19:0] log_result_q;
	logic        domain_error_q;

	// the whole pipe moves when the output slot is free or being taken
	assign en          = !out_valid_q || out_ch.ready;
	assign in_ch.ready = en;

	fpln_norm u_norm (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (in_ch.valid),
		.x        (in_ch.x_value),
		.st_s2    (st_s2)
	);

	fpln_reduce u_reduce (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.st_s2  (st_s2),
		.st_s4  (st_s4)
	);

	fpln_cubic u_cubic (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.st_s4  (st_s4),
		.st_s7  (st_s7)
	);

	// table entry plus scaled remainder plus (16 - shift) * ln2, wrapping at 32 bits
	assign sum = st_s7.logck + {{8{st_s7.r2[28]}}, st_s7.r2[28:5]} + st_s7.lnsh;
	// round away 12 bits, then remove the offset of 12.0
	assign rnd = {1'b0, sum[31:12]} + {20'b0, sum[11]};
	assign res = rnd - {1'b0, OFFSET_12};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= st_s7.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			log_result_q   <= st_s7.err ? 20'd0 : res[19:0];
			domain_error_q <= st_s7.err;
		end
	end

	assign out_ch.valid        = out_valid_q;
	assign out_ch.log_result   = log_result_q;
	assign out_ch.domain_error = domain_error_q;

endmodule
